// ----- src/pts_pkg.sv -----
// pts_pkg: shared constants, codes and types of the periodic task scheduler
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package pts_pkg;

   localparam int NUM_SLOTS   = 16;
   localparam int PERIOD_BITS = 24;
   localparam int TIME_BITS   = 32;
   localparam int MAX_OUT     = 16;

   localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
   localparam int COUNT_BITS  = $clog2(MAX_OUT);
   localparam int FSLOT_BITS  = 4;
   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 2;

   // width wide enough to compare a period against half the time range
   localparam int CMP_BITS = (PERIOD_BITS > TIME_BITS) ? PERIOD_BITS : TIME_BITS;
   localparam logic [CMP_BITS-1:0] TIME_HALF_W = CMP_BITS'(1) << (TIME_BITS - 1);
   localparam logic [PERIOD_BITS-1:0] PERIOD_CLAMP = PERIOD_BITS'(TIME_HALF_W - 1'b1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACTION_BITS-1:0] ACT_SCHEDULE   = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DESCHEDULE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_TICK       = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_QUERY      = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INACTIVE = 2'd2;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [FSLOT_BITS-1:0]  slot;
      logic                   slot_ok;
      logic [PERIOD_BITS-1:0] period;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [FSLOT_BITS-1:0]  slot;
      logic                   running;
      logic                   fired;
      logic                   last;
   } rsp_type;

endpackage

// ----- src/pts_front.sv -----
// pts_front: accepts requests, range-checks the slot and fixes up the period
// depends on pts_pkg; feeds pts_queue
`timescale 1ns / 1ps

module pts_front (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pts_pkg::ACTION_BITS-1:0]   req_action,
   input  logic [pts_pkg::FSLOT_BITS-1:0]    req_task_slot,
   input  logic [pts_pkg::PERIOD_BITS-1:0]   req_period_ticks,
   input  logic                              q_full,
   output logic                              q_push,
   output pts_pkg::cmd_type                  q_cmd
);

   logic [pts_pkg::CMP_BITS-1:0] period_wide;

   assign req_ready   = !q_full;
   assign q_push      = req_valid && !q_full;
   assign period_wide = pts_pkg::CMP_BITS'(req_period_ticks);

   always_comb begin
      q_cmd.action  = req_action;
      q_cmd.slot    = req_task_slot;
      q_cmd.slot_ok = (32'(req_task_slot) < pts_pkg::NUM_SLOTS);
      if (req_period_ticks == '0) begin
         q_cmd.period = pts_pkg::PERIOD_BITS'(1);
      end else if (period_wide >= pts_pkg::TIME_HALF_W) begin
         q_cmd.period = pts_pkg::PERIOD_CLAMP;
      end else begin
         q_cmd.period = req_period_ticks;
      end
   end

endmodule

// ----- src/pts_queue.sv -----
// pts_queue: short fifo of classified requests between front and back
// depends on pts_pkg
`timescale 1ns / 1ps

module pts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   input  pts_pkg::cmd_type  q_cmd,
   output logic              q_full,
   output logic              q_valid,
   output pts_pkg::cmd_type  q_head,
   input  logic              q_pop
);

   pts_pkg::cmd_type                 entry_ff [pts_pkg::QUEUE_DEPTH];
   logic [pts_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pts_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pts_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                             do_push, do_pop;

   assign q_full  = (count_ff == pts_pkg::QCNT_BITS'(pts_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pts_pkg::QPTR_BITS'(pts_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pts_pkg::QPTR_BITS'(pts_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_cmd;
      end
   end

endmodule

// ----- src/pts_back.sv -----
// pts_back: slot table, tick counter and deadline scan sequencer
// depends on pts_pkg; takes requests from pts_queue, drives the response register
`timescale 1ns / 1ps

module pts_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pts_pkg::cmd_type  q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pts_pkg::rsp_type  rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIRE  = 2'd3;

   localparam int SB = pts_pkg::SLOT_BITS;
   localparam int TB = pts_pkg::TIME_BITS;
   localparam int PB = pts_pkg::PERIOD_BITS;

   logic [PB-1:0] slot_period_mem   [pts_pkg::NUM_SLOTS];
   logic [TB-1:0] slot_deadline_mem [pts_pkg::NUM_SLOTS];

   logic [1:0]                    state_ff, state_in;
   logic [pts_pkg::NUM_SLOTS-1:0] active_ff, active_in;
   logic [TB-1:0]                 time_ff, time_in;
   logic [SB-1:0]                 scan_idx_ff, scan_idx_in;
   logic [SB-1:0]                 cand_idx_ff, cand_idx_in;
   logic                          cand_vld_ff, cand_vld_in;
   logic [1:0]                    due_cnt_ff, due_cnt_in;
   logic [SB-1:0]                 best_idx_ff, best_idx_in;
   logic [TB-1:0]                 best_age_ff, best_age_in;
   logic [PB-1:0]                 best_period_ff, best_period_in;
   logic [pts_pkg::COUNT_BITS-1:0] n_ff, n_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pts_pkg::rsp_type              rsp_ff, rsp_in;

   logic [TB-1:0] rd_deadline_ff;
   logic [PB-1:0] rd_period_ff;

   logic          dl_wr, pr_wr;
   logic [SB-1:0] dl_addr;
   logic [TB-1:0] dl_data;

   logic          out_free;
   logic [SB-1:0] free_idx;
   logic          any_free;
   logic [SB-1:0] cmd_idx;
   logic          cmd_active;
   logic [TB-1:0] cand_age;
   logic          cand_due;
   logic          fire_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cmd_idx    = SB'(q_head.slot);
   assign cmd_active = q_head.slot_ok && active_ff[cmd_idx];

   // age is how far the new time has moved past the stored deadline
   assign cand_age  = time_ff - rd_deadline_ff;
   assign cand_due  = cand_vld_ff && active_ff[cand_idx_ff] && !cand_age[TB-1];
   assign fire_last = (due_cnt_ff == 2'd1) ||
                      (n_ff == pts_pkg::COUNT_BITS'(pts_pkg::MAX_OUT - 1));

   // lowest free slot
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = pts_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = SB'(i);
            any_free = 1'b1;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      time_in        = time_ff;
      scan_idx_in    = scan_idx_ff;
      cand_idx_in    = cand_idx_ff;
      cand_vld_in    = cand_vld_ff;
      due_cnt_in     = due_cnt_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      best_period_in = best_period_ff;
      n_in           = n_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      q_pop          = 1'b0;
      dl_wr          = 1'b0;
      pr_wr          = 1'b0;
      dl_addr        = free_idx;
      dl_data        = time_ff + 1'b1;

      // ascending scan: strict compare keeps the lower slot on a tie
      if (cand_due) begin
         if (due_cnt_ff == 2'd0 || cand_age > best_age_ff) begin
            best_idx_in    = cand_idx_ff;
            best_age_in    = cand_age;
            best_period_in = rd_period_ff;
         end
         if (due_cnt_ff != 2'd2) begin
            due_cnt_in = due_cnt_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_head.action)
                  pts_pkg::ACT_SCHEDULE: begin
                     rsp_valid_in = 1'b1;
                     if (!any_free) begin
                        rsp_in = '{pts_pkg::STATUS_FULL, '0, 1'b0, 1'b0, 1'b1};
                     end else begin
                        active_in[free_idx] = 1'b1;
                        dl_wr  = 1'b1;
                        pr_wr  = 1'b1;
                        rsp_in = '{pts_pkg::STATUS_OK, pts_pkg::FSLOT_BITS'(free_idx),
                                   1'b1, 1'b0, 1'b1};
                     end
                  end
                  pts_pkg::ACT_DESCHEDULE: begin
                     rsp_valid_in = 1'b1;
                     if (cmd_active) begin
                        active_in[cmd_idx] = 1'b0;
                        rsp_in = '{pts_pkg::STATUS_OK, q_head.slot, 1'b0, 1'b0, 1'b1};
                     end else begin
                        rsp_in = '{pts_pkg::STATUS_INACTIVE, q_head.slot,
                                   1'b0, 1'b0, 1'b1};
                     end
                  end
                  pts_pkg::ACT_QUERY: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{pts_pkg::STATUS_OK, q_head.slot, cmd_active, 1'b0, 1'b1};
                  end
                  pts_pkg::ACT_TICK: begin
                     time_in     = time_ff + 1'b1;
                     scan_idx_in = '0;
                     cand_vld_in = 1'b0;
                     due_cnt_in  = 2'd0;
                     n_in        = '0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cand_idx_in = scan_idx_ff;
            cand_vld_in = 1'b1;
            if (scan_idx_ff == SB'(pts_pkg::NUM_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cand_vld_in = 1'b0;
            state_in    = ST_FIRE;
         end
         ST_FIRE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (due_cnt_ff == 2'd0) begin
                  rsp_in   = '{pts_pkg::STATUS_OK, '0, 1'b0, 1'b0, 1'b1};
                  state_in = ST_IDLE;
               end else begin
                  rsp_in  = '{pts_pkg::STATUS_OK, pts_pkg::FSLOT_BITS'(best_idx_ff),
                              1'b1, 1'b1, fire_last};
                  dl_wr   = 1'b1;
                  dl_addr = best_idx_ff;
                  dl_data = time_ff + TB'(best_period_ff);
                  if (fire_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     n_in        = n_ff + 1'b1;
                     scan_idx_in = '0;
                     due_cnt_in  = 2'd0;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         time_ff      <= '0;
         cand_vld_ff  <= 1'b0;
         due_cnt_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         time_ff      <= time_in;
         cand_vld_ff  <= cand_vld_in;
         due_cnt_ff   <= due_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      cand_idx_ff    <= cand_idx_in;
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      best_period_ff <= best_period_in;
      n_ff           <= n_in;
      rsp_ff         <= rsp_in;
   end

   // slot tables, one entry read per cycle at the scan index
   always_ff @(posedge clock) begin
      if (dl_wr) begin
         slot_deadline_mem[dl_addr] <= dl_data;
      end
      if (pr_wr) begin
         slot_period_mem[free_idx] <= q_head.period;
      end
      rd_deadline_ff <= slot_deadline_mem[scan_idx_ff];
      rd_period_ff   <= slot_period_mem[scan_idx_ff];
   end

endmodule

// ----- src/periodic_task_deadline_scheduler.sv -----
// periodic_task_deadline_scheduler: top level of the periodic task scheduler
// depends on pts_pkg, pts_front, pts_queue and pts_back
//
// usage: a request (req_*) carries an action: schedule claims the lowest free
// slot with a period in ticks, deschedule frees req_task_slot, query reports
// whether req_task_slot is active, tick advances time by one and fires every
// due slot, earliest deadline first, ties to the lower slot.
// every request but a tick gives one response with rsp_last set. a tick gives
// one response per fired slot (rsp_fired set, rsp_last on the final one), or
// a single empty response when nothing is due.
// a two-entry request queue sits between the front and the slot table, so
// requests are taken while a response waits on rsp_ready.
// schedule, deschedule and query responses are registered and come one per cycle
// back to back while rsp_ready stays high. a tick scans the slot table one entry
// per cycle, then drains the read pipeline and gives its first response (or the
// empty one); each further fired response follows a fresh scan of the table.
// a stalled receiver holds the response register and a tick waits with it in its fire step.
// reset clears all slots, the tick counter and both channels.
`timescale 1ns / 1ps

module periodic_task_deadline_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pts_pkg::ACTION_BITS-1:0]   req_action,
   input  logic [pts_pkg::FSLOT_BITS-1:0]    req_task_slot,
   input  logic [pts_pkg::PERIOD_BITS-1:0]   req_period_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pts_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [pts_pkg::FSLOT_BITS-1:0]    rsp_task_slot_out,
   output logic                              rsp_running,
   output logic                              rsp_fired,
   output logic                              rsp_last
);

   logic             q_full, q_push, q_valid, q_pop;
   pts_pkg::cmd_type q_cmd, q_head;
   pts_pkg::rsp_type rsp;

   pts_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_task_slot    (req_task_slot),
      .req_period_ticks (req_period_ticks),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_cmd)
   );

   pts_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_cmd   (q_cmd),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   pts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_status        = rsp.status;
   assign rsp_task_slot_out = rsp.slot;
   assign rsp_running       = rsp.running;
   assign rsp_fired         = rsp.fired;
   assign rsp_last          = rsp.last;

endmodule

// ----- src/pts_checker.sv -----
// pts_checker: port-level assertions for the periodic task scheduler
// depends on pts_pkg; bound to periodic_task_deadline_scheduler
`timescale 1ns / 1ps

module pts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pts_pkg::STATUS_BITS-1:0]   rsp_status,
   input logic [pts_pkg::FSLOT_BITS-1:0]    rsp_task_slot_out,
   input logic                              rsp_running,
   input logic                              rsp_fired,
   input logic                              rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_task_slot_out) && $stable(rsp_running) &&
      $stable(rsp_fired) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // only a tick gives more than one response
   a_multi_is_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_fired)
      else $error("non-final response that is not a fired slot");

   a_fire_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_status == pts_pkg::STATUS_OK && rsp_running)
      else $error("fired response with bad status or running");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pts_pkg::STATUS_FULL |->
      rsp_task_slot_out == '0 && !rsp_running && !rsp_fired && rsp_last)
      else $error("table full response with bad fields");

endmodule

bind periodic_task_deadline_scheduler pts_checker u_pts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_task_slot_out (rsp_task_slot_out),
   .rsp_running       (rsp_running),
   .rsp_fired         (rsp_fired),
   .rsp_last          (rsp_last)
);
